FILE: design/tsac_pkg.sv
`timescale 1ns / 1ps

package tsac_pkg;

    // Cache geometry
    localparam int SET_INDEX_BITS = 14;
    localparam int NUM_SETS       = 1 << SET_INDEX_BITS;
    localparam int TAG_BITS       = 30 - SET_INDEX_BITS;
    localparam int LINE_BITS      = 32;

    // Operation codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_INVAL = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RESOLVE
    } ctl_state_t;

    // Per-set bookkeeping: replacement way and both valid bits
    typedef struct packed {
        logic lru;
        logic valid1;
        logic valid0;
    } set_meta_t;

    // One way entry: tag and line
    typedef struct packed {
        logic [TAG_BITS-1:0]  tag;
        logic [LINE_BITS-1:0] line;
    } way_entry_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic clear_step;
        logic commit;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic req_inval;
        logic clear_last;
    } dp_status_t;

endpackage

FILE: design/two_way_set_assoc_cache_unit.sv
`timescale 1ns / 1ps

// Two-way set-associative byte cache with 4-byte lines, one LRU bit per set
// and 32-bit hit/miss counters. The set is read from the tag, line and
// bookkeeping memories at the edge that accepts the transaction, and the
// compare, fill and result load happen once the output register is free;
// no new access is accepted before that. The result sits in an output
// register, so the next access may be accepted while it waits.
// After reset and after every invalidate the block runs a clearing pass over
// the bookkeeping memory, one set per cycle over 16384 sets at the default
// geometry (2**SET_INDEX_BITS), and accepts no transaction during that pass.
// The invalidate result is loaded into the output register as the pass starts
// and may be taken by the receiver while the pass runs.
module two_way_set_assoc_cache_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [31:0] address,
    input  logic [31:0] fill_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_byte,
    output logic        was_hit,
    output logic        way_used,
    output logic [31:0] hits_so_far,
    output logic [31:0] misses_so_far
);
    import tsac_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t status;

    // Sequencer
    tsac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Memories, compare and counters
    tsac_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .opcode        (opcode),
        .address       (address),
        .fill_word     (fill_word),
        .read_byte     (read_byte),
        .was_hit       (was_hit),
        .way_used      (way_used),
        .hits_so_far   (hits_so_far),
        .misses_so_far (misses_so_far)
    );

endmodule

FILE: design/tsac_ctrl.sv
`timescale 1ns / 1ps

module tsac_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  tsac_pkg::dp_status_t status,
    output tsac_pkg::ctl_cmd_t   cmd
);
    import tsac_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // Output slot is free when empty or being drained this cycle
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (out_free)
                begin
                    state_next = status.req_inval ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Outputs and commands
    always_comb
    begin
        in_stall       = 1'b1;
        cmd.capture    = 1'b0;
        cmd.clear_step = 1'b0;
        cmd.commit     = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            ST_RESOLVE:
            begin
                cmd.commit = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Hold a result until the transaction completes
    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: design/tsac_datapath.sv
`timescale 1ns / 1ps

module tsac_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tsac_pkg::ctl_cmd_t   cmd,
    output tsac_pkg::dp_status_t status,
    input  logic                 opcode,
    input  logic [31:0]          address,
    input  logic [31:0]          fill_word,
    output logic [7:0]           read_byte,
    output logic                 was_hit,
    output logic                 way_used,
    output logic [31:0]          hits_so_far,
    output logic [31:0]          misses_so_far
);
    import tsac_pkg::*;

    // Storage
    set_meta_t  meta_mem [NUM_SETS];
    way_entry_t way0_mem [NUM_SETS];
    way_entry_t way1_mem [NUM_SETS];

    // Registered read data
    set_meta_t  meta_rd_reg;
    way_entry_t way0_rd_reg;
    way_entry_t way1_rd_reg;

    // Captured request
    logic        req_op_reg;
    logic [31:0] req_addr_reg;
    logic [31:0] req_fill_reg;

    // Clearing sweep
    logic [SET_INDEX_BITS-1:0] clr_idx_reg;
    logic [SET_INDEX_BITS-1:0] clr_idx_next;

    // Counters and result
    logic [31:0] hit_cnt_reg;
    logic [31:0] hit_cnt_next;
    logic [31:0] miss_cnt_reg;
    logic [31:0] miss_cnt_next;
    logic [7:0]  byte_reg;
    logic [7:0]  byte_next;
    logic        hit_reg;
    logic        hit_next;
    logic        way_reg;
    logic        way_next;

    // Lookup terms
    logic [SET_INDEX_BITS-1:0] rd_set;
    logic [SET_INDEX_BITS-1:0] req_set;
    logic [TAG_BITS-1:0]       req_tag;
    logic                      hit0;
    logic                      hit1;
    logic                      any_hit;
    logic                      sel_way;
    logic [LINE_BITS-1:0]      sel_line;
    set_meta_t                 meta_new;
    way_entry_t                fill_entry;
    logic                      is_inval;

    assign rd_set   = address[SET_INDEX_BITS+1:2];
    assign req_set  = req_addr_reg[SET_INDEX_BITS+1:2];
    assign req_tag  = req_addr_reg[31:SET_INDEX_BITS+2];
    assign is_inval = (req_op_reg == OP_INVAL);

    assign status.req_inval  = is_inval;
    assign status.clear_last = (clr_idx_reg == {SET_INDEX_BITS{1'b1}});

    // Capture the request and read the addressed set
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_op_reg   <= opcode;
            req_addr_reg <= address;
            req_fill_reg <= fill_word;
            meta_rd_reg  <= meta_mem[rd_set];
            way0_rd_reg  <= way0_mem[rd_set];
            way1_rd_reg  <= way1_mem[rd_set];
        end
    end

    // Tag compare, way 0 first; on a miss pick the replacement way
    always_comb
    begin
        hit0     = meta_rd_reg.valid0 && (way0_rd_reg.tag == req_tag);
        hit1     = meta_rd_reg.valid1 && (way1_rd_reg.tag == req_tag);
        any_hit  = hit0 || hit1;
        if (hit0)
        begin
            sel_way  = 1'b0;
            sel_line = way0_rd_reg.line;
        end
        else if (hit1)
        begin
            sel_way  = 1'b1;
            sel_line = way1_rd_reg.line;
        end
        else
        begin
            sel_way  = meta_rd_reg.lru;
            sel_line = req_fill_reg;
        end
        meta_new.lru    = ~sel_way;
        meta_new.valid0 = meta_rd_reg.valid0 || (!any_hit && !sel_way);
        meta_new.valid1 = meta_rd_reg.valid1 || (!any_hit && sel_way);
        fill_entry.tag  = req_tag;
        fill_entry.line = req_fill_reg;
    end

    // Update set bookkeeping: sweep clear or commit of an access
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            meta_mem[clr_idx_reg] <= '0;
        end
        else if (cmd.commit && !is_inval)
        begin
            meta_mem[req_set] <= meta_new;
        end
    end

    // Fill the replaced way on a miss
    always_ff @(posedge clk)
    begin
        if (cmd.commit && !is_inval && !any_hit && !sel_way)
        begin
            way0_mem[req_set] <= fill_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && !is_inval && !any_hit && sel_way)
        begin
            way1_mem[req_set] <= fill_entry;
        end
    end

    // Advance the sweep index; it wraps to zero after the last set
    assign clr_idx_next = cmd.clear_step ? clr_idx_reg + SET_INDEX_BITS'(1) : clr_idx_reg;

    // Select the addressed byte
    always_comb
    begin
        case (req_addr_reg[1:0])
            2'd0:    byte_next = sel_line[7:0];
            2'd1:    byte_next = sel_line[15:8];
            2'd2:    byte_next = sel_line[23:16];
            default: byte_next = sel_line[31:24];
        endcase
        if (is_inval)
        begin
            byte_next = 8'd0;
        end
    end

    // Counters and result fields
    always_comb
    begin
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        hit_next      = 1'b0;
        way_next      = 1'b0;
        if (is_inval)
        begin
            hit_cnt_next  = 32'd0;
            miss_cnt_next = 32'd0;
        end
        else
        begin
            hit_next = any_hit;
            way_next = sel_way;
            if (any_hit)
            begin
                hit_cnt_next = hit_cnt_reg + 32'd1;
            end
            else
            begin
                miss_cnt_next = miss_cnt_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg  <= '0;
            hit_cnt_reg  <= 32'd0;
            miss_cnt_reg <= 32'd0;
        end
        else
        begin
            clr_idx_reg <= clr_idx_next;
            if (cmd.commit)
            begin
                hit_cnt_reg  <= hit_cnt_next;
                miss_cnt_reg <= miss_cnt_next;
            end
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            byte_reg <= byte_next;
            hit_reg  <= hit_next;
            way_reg  <= way_next;
        end
    end

    assign read_byte     = byte_reg;
    assign was_hit       = hit_reg;
    assign way_used      = way_reg;
    assign hits_so_far   = hit_cnt_reg;
    assign misses_so_far = miss_cnt_reg;

endmodule
